// ===== src/cbb_pkg.sv =====
// Shared types, constants and rounding helpers for the circle/box bounce pipeline
`timescale 1ns / 1ps
`default_nettype none
package cbb_pkg;

    // Pipeline depths of the iterative units and the fraction width
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 17;
    localparam int FRAC_BITS   = 16;

    // Unity in Q1.16 and the restitution reset value (0.75)
    localparam logic [16:0] Q_ONE          = 17'd65536;
    localparam logic [16:0] RESTITUTION_RST = 17'd49152;

    // Configuration register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_BOX_CENTER_X = 3'd0,
        REG_BOX_CENTER_Y = 3'd1,
        REG_BOX_WIDTH    = 3'd2,
        REG_BOX_HEIGHT   = 3'd3,
        REG_RESTITUTION  = 3'd4
    } reg_idx_t;

    // Per-word payload carried alongside the square root and divider
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic        [30:0] r;
        logic signed [33:0] px;
        logic signed [33:0] py;
        logic        [30:0] adx;
        logic        [30:0] ady;
        logic               sx;
        logic               sy;
        logic               hit;
        logic               zero;
    } tag_t;

    // Divide by 2^16, rounding to nearest with halves away from zero
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? (~v + 64'd1) : v;
        m = (m + 64'd32768) >> FRAC_BITS;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    // Saturate to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'h7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/circle_box_bounce.sv =====
// Top level: stream ports, configuration registers and the collision pipeline
//
// Circle against axis-aligned box collision with a restitution bounce.
// Input stream (s_*): one word per circle query (centre, velocity, radius).
// Output stream (m_*): one word per query with the hit flag, the resolved
// centre and the resulting velocity, in query order.
// Configuration: APB port with box centre, box size and restitution at
// byte addresses 0, 4, 8, 12 and 16; write only while the pipeline is empty.
// Depth: 59 register stages (3 front stages, 32 square-root stages,
// 17 divider stages, 7 back-end stages).
// Throughput: one word per cycle while the output is not stalled; the depth
// is set by the square root, which resolves one root bit in each stage.
// Reset clears all valid bits and loads the register reset values
// (restitution 0.75). When the receiver holds m_tready low with a word
// waiting, the whole pipeline freezes and s_tready drops; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module circle_box_bounce
    import cbb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // circle_x[31:0], circle_y[63:32], vel_x[95:64], vel_y[127:96],
    // circle_radius[158:128], zero[159]
    input  wire logic [159:0] s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // hit[0], out_x[32:1], out_y[64:33], out_vel_x[96:65], out_vel_y[128:97],
    // zero[135:129]
    output logic      [135:0] m_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic   [4:0] paddr,
    input  wire logic  [31:0] pwdata,
    output logic       [31:0] prdata,
    output logic              pready
);

    logic signed [31:0] box_center_x_reg, box_center_y_reg;
    logic        [30:0] box_width_reg, box_height_reg;
    logic        [16:0] restitution_reg;
    logic               cfg_wr;
    logic               en;

    logic               fr_valid, sq_valid, dv_valid;
    tag_t               fr_tag, sq_tag, dv_tag;
    logic        [62:0] fr_d2;
    logic        [31:0] sq_dist;
    logic        [16:0] dv_qx, dv_qy;
    logic               res_hit;
    logic signed [31:0] res_x, res_y, res_vx, res_vy;

    // Configuration writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_center_x_reg <= '0;
            box_center_y_reg <= '0;
            box_width_reg    <= '0;
            box_height_reg   <= '0;
            restitution_reg  <= RESTITUTION_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_BOX_CENTER_X: box_center_x_reg <= pwdata;
                REG_BOX_CENTER_Y: box_center_y_reg <= pwdata;
                REG_BOX_WIDTH:    box_width_reg    <= pwdata[30:0];
                REG_BOX_HEIGHT:   box_height_reg   <= pwdata[30:0];
                REG_RESTITUTION:  restitution_reg  <= pwdata[16:0];
                default:          ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (paddr[4:2])
            REG_BOX_CENTER_X: prdata = box_center_x_reg;
            REG_BOX_CENTER_Y: prdata = box_center_y_reg;
            REG_BOX_WIDTH:    prdata = {1'b0, box_width_reg};
            REG_BOX_HEIGHT:   prdata = {1'b0, box_height_reg};
            REG_RESTITUTION:  prdata = {15'd0, restitution_reg};
            default:          prdata = '0;
        endcase
    end

    // Freeze every stage while the output word waits
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    cbb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (s_tvalid),
        .circle_x      (s_tdata[31:0]),
        .circle_y      (s_tdata[63:32]),
        .vel_x         (s_tdata[95:64]),
        .vel_y         (s_tdata[127:96]),
        .circle_radius (s_tdata[158:128]),
        .box_center_x  (box_center_x_reg),
        .box_center_y  (box_center_y_reg),
        .box_width     (box_width_reg),
        .box_height    (box_height_reg),
        .out_valid     (fr_valid),
        .out_tag       (fr_tag),
        .out_d2        (fr_d2)
    );

    cbb_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_tag    (fr_tag),
        .in_d2     (fr_d2),
        .out_valid (sq_valid),
        .out_tag   (sq_tag),
        .out_dist  (sq_dist)
    );

    cbb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_tag    (sq_tag),
        .in_dist   (sq_dist),
        .out_valid (dv_valid),
        .out_tag   (dv_tag),
        .out_qx    (dv_qx),
        .out_qy    (dv_qy)
    );

    cbb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (dv_valid),
        .in_tag      (dv_tag),
        .in_qx       (dv_qx),
        .in_qy       (dv_qy),
        .restitution (restitution_reg),
        .out_valid   (m_tvalid),
        .hit         (res_hit),
        .out_x       (res_x),
        .out_y       (res_y),
        .out_vel_x   (res_vx),
        .out_vel_y   (res_vy)
    );

    assign m_tdata = {7'd0, res_vy, res_vx, res_y, res_x, res_hit};

endmodule
`default_nettype wire

// ===== src/cbb_front.sv =====
// Front end: clamp to the box, squared distance and overlap test (three stages)
`timescale 1ns / 1ps
`default_nettype none
module cbb_front
    import cbb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic signed [31:0] circle_x,
    input  wire logic signed [31:0] circle_y,
    input  wire logic signed [31:0] vel_x,
    input  wire logic signed [31:0] vel_y,
    input  wire logic        [30:0] circle_radius,
    input  wire logic signed [31:0] box_center_x,
    input  wire logic signed [31:0] box_center_y,
    input  wire logic        [30:0] box_width,
    input  wire logic        [30:0] box_height,
    output logic                    out_valid,
    output tag_t                    out_tag,
    output logic             [62:0] out_d2
);

    logic signed [33:0] lo_x, hi_x, lo_y, hi_y, x34, y34, px, py;
    logic signed [34:0] dx, dy;

    logic               f1_valid_reg;
    logic signed [31:0] f1_x_reg, f1_y_reg, f1_vx_reg, f1_vy_reg;
    logic        [30:0] f1_r_reg;
    logic signed [33:0] f1_px_reg, f1_py_reg;
    logic signed [34:0] f1_dx_reg, f1_dy_reg;

    logic        [34:0] adx, ady;
    logic               near;
    tag_t               f2_tag_next;

    logic               f2_valid_reg;
    tag_t               f2_tag_reg;
    logic        [61:0] f2_sqx_reg, f2_sqy_reg, f2_r2_reg;
    logic               f2_near_reg;

    logic        [62:0] d2;
    tag_t               f3_tag_next;

    logic               f3_valid_reg;
    tag_t               f3_tag_reg;
    logic        [62:0] f3_d2_reg;

    // Clamp the centre to the box edges
    always_comb
    begin
        lo_x = 34'(box_center_x) - $signed({4'd0, box_width[30:1]});
        hi_x = 34'(box_center_x) + $signed({4'd0, box_width[30:1]});
        lo_y = 34'(box_center_y) - $signed({4'd0, box_height[30:1]});
        hi_y = 34'(box_center_y) + $signed({4'd0, box_height[30:1]});
        x34  = 34'(circle_x);
        y34  = 34'(circle_y);
        px   = (x34 < lo_x) ? lo_x : ((x34 > hi_x) ? hi_x : x34);
        py   = (y34 < lo_y) ? lo_y : ((y34 > hi_y) ? hi_y : y34);
        dx   = 35'(x34) - 35'(px);
        dy   = 35'(y34) - 35'(py);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg <= in_valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_x_reg  <= circle_x;
            f1_y_reg  <= circle_y;
            f1_vx_reg <= vel_x;
            f1_vy_reg <= vel_y;
            f1_r_reg  <= circle_radius;
            f1_px_reg <= px;
            f1_py_reg <= py;
            f1_dx_reg <= dx;
            f1_dy_reg <= dy;
        end
    end

    // Take magnitudes and test each axis against the radius
    always_comb
    begin
        adx  = f1_dx_reg[34] ? 35'(-f1_dx_reg) : 35'(f1_dx_reg);
        ady  = f1_dy_reg[34] ? 35'(-f1_dy_reg) : 35'(f1_dy_reg);
        near = (adx < {4'd0, f1_r_reg}) && (ady < {4'd0, f1_r_reg});
        f2_tag_next      = '0;
        f2_tag_next.x    = f1_x_reg;
        f2_tag_next.y    = f1_y_reg;
        f2_tag_next.vx   = f1_vx_reg;
        f2_tag_next.vy   = f1_vy_reg;
        f2_tag_next.r    = f1_r_reg;
        f2_tag_next.px   = f1_px_reg;
        f2_tag_next.py   = f1_py_reg;
        f2_tag_next.adx  = adx[30:0];
        f2_tag_next.ady  = ady[30:0];
        f2_tag_next.sx   = f1_dx_reg[34];
        f2_tag_next.sy   = f1_dy_reg[34];
    end

    // Square the offsets and the radius
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f2_tag_reg  <= f2_tag_next;
            f2_sqx_reg  <= adx[30:0] * adx[30:0];
            f2_sqy_reg  <= ady[30:0] * ady[30:0];
            f2_r2_reg   <= f1_r_reg * f1_r_reg;
            f2_near_reg <= near;
        end
    end

    // Sum the squares and compare with the squared radius
    always_comb
    begin
        d2               = {1'b0, f2_sqx_reg} + {1'b0, f2_sqy_reg};
        f3_tag_next      = f2_tag_reg;
        f3_tag_next.hit  = f2_near_reg && (d2 < {1'b0, f2_r2_reg});
        f3_tag_next.zero = (d2 == 63'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f3_tag_reg <= f3_tag_next;
            f3_d2_reg  <= d2;
        end
    end

    assign out_valid = f3_valid_reg;
    assign out_tag   = f3_tag_reg;
    assign out_d2    = f3_d2_reg;

endmodule
`default_nettype wire

// ===== src/cbb_sqrt.sv =====
// Pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none
module cbb_sqrt
    import cbb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire tag_t        in_tag,
    input  wire logic [62:0] in_d2,
    output logic             out_valid,
    output tag_t             out_tag,
    output logic      [31:0] out_dist
);

    logic        vld_reg [SQRT_STAGES];
    tag_t        tag_reg [SQRT_STAGES];
    logic [63:0] v_reg   [SQRT_STAGES];
    logic [63:0] q_reg   [SQRT_STAGES];

    genvar k;
    for (k = 0; k < SQRT_STAGES; k++)
    begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);

        logic        vld_in;
        tag_t        tag_in;
        logic [63:0] v_in, q_in, trial, v_next, q_next;

        if (k == 0)
        begin : g_first
            assign vld_in = in_valid;
            assign tag_in = in_tag;
            assign v_in   = {1'b0, in_d2};
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign vld_in = vld_reg[k-1];
            assign tag_in = tag_reg[k-1];
            assign v_in   = v_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        // Try the next root bit; keep it when the remainder allows
        always_comb
        begin
            trial = q_in + BIT;
            if (v_in >= trial)
            begin
                v_next = v_in - trial;
                q_next = (q_in >> 1) + BIT;
            end
            else
            begin
                v_next = v_in;
                q_next = q_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[k] <= tag_in;
                v_reg[k]   <= v_next;
                q_reg[k]   <= q_next;
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STAGES-1];
    assign out_tag   = tag_reg[SQRT_STAGES-1];
    assign out_dist  = q_reg[SQRT_STAGES-1][31:0];

endmodule
`default_nettype wire

// ===== src/cbb_div.sv =====
// Pipelined restoring divider for both normal components, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module cbb_div
    import cbb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire tag_t        in_tag,
    input  wire logic [31:0] in_dist,
    output logic             out_valid,
    output tag_t             out_tag,
    output logic      [16:0] out_qx,
    output logic      [16:0] out_qy
);

    logic        vld_reg  [DIV_STAGES];
    tag_t        tag_reg  [DIV_STAGES];
    logic [31:0] dist_reg [DIV_STAGES];
    logic [47:0] rx_reg   [DIV_STAGES];
    logic [47:0] ry_reg   [DIV_STAGES];
    logic [16:0] qx_reg   [DIV_STAGES];
    logic [16:0] qy_reg   [DIV_STAGES];

    genvar k;
    for (k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        localparam int SH = DIV_STAGES - 1 - k;

        logic        vld_in;
        tag_t        tag_in;
        logic [31:0] dist_in;
        logic [47:0] rx_in, ry_in, dsh, rx_next, ry_next;
        logic [16:0] qx_in, qy_in;
        logic        gex, gey;

        if (k == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign tag_in  = in_tag;
            assign dist_in = in_dist;
            assign rx_in   = {1'b0, in_tag.adx, 16'd0};
            assign ry_in   = {1'b0, in_tag.ady, 16'd0};
            assign qx_in   = '0;
            assign qy_in   = '0;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[k-1];
            assign tag_in  = tag_reg[k-1];
            assign dist_in = dist_reg[k-1];
            assign rx_in   = rx_reg[k-1];
            assign ry_in   = ry_reg[k-1];
            assign qx_in   = qx_reg[k-1];
            assign qy_in   = qy_reg[k-1];
        end

        // Subtract the shifted divisor where it fits
        always_comb
        begin
            dsh     = {16'd0, dist_in} << SH;
            gex     = (rx_in >= dsh);
            gey     = (ry_in >= dsh);
            rx_next = gex ? (rx_in - dsh) : rx_in;
            ry_next = gey ? (ry_in - dsh) : ry_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[k]  <= tag_in;
                dist_reg[k] <= dist_in;
                rx_reg[k]   <= rx_next;
                ry_reg[k]   <= ry_next;
                qx_reg[k]   <= {qx_in[15:0], gex};
                qy_reg[k]   <= {qy_in[15:0], gey};
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign out_tag   = tag_reg[DIV_STAGES-1];
    assign out_qx    = qx_reg[DIV_STAGES-1];
    assign out_qy    = qy_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== src/cbb_back.sv =====
// Back end: push-out, dot product, restitution impulse and saturation (seven stages)
`timescale 1ns / 1ps
`default_nettype none
module cbb_back
    import cbb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire tag_t               in_tag,
    input  wire logic        [16:0] in_qx,
    input  wire logic        [16:0] in_qy,
    input  wire logic        [16:0] restitution,
    output logic                    out_valid,
    output logic                    hit,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_vel_x,
    output logic signed [31:0]      out_vel_y
);

    logic               b1_valid_reg, b2_valid_reg, b3_valid_reg, b4_valid_reg;
    logic               b5_valid_reg, b6_valid_reg, out_valid_reg;
    tag_t               b1_tag_reg, b2_tag_reg, b3_tag_reg, b4_tag_reg, b5_tag_reg, b6_tag_reg;

    logic signed [17:0] nx_next, ny_next;
    logic signed [17:0] b1_nx_reg, b1_ny_reg, b2_nx_reg, b2_ny_reg, b3_nx_reg, b3_ny_reg;
    logic signed [17:0] b4_nx_reg, b4_ny_reg, b5_nx_reg, b5_ny_reg;
    logic signed [49:0] b2_pnx_reg, b2_pny_reg, b2_pvx_reg, b2_pvy_reg;
    logic signed [63:0] dot64, offx64, offy64;
    logic signed [35:0] b3_ox_reg, b3_oy_reg, b4_ox_reg, b4_oy_reg, b5_ox_reg, b5_oy_reg;
    logic signed [35:0] b6_ox_reg, b6_oy_reg;
    logic signed [34:0] b3_dot_reg, b4_dot_reg, b5_dot_reg, b6_dot_reg;
    logic        [16:0] e_lim;
    logic signed [18:0] fac;
    logic signed [53:0] b4_jp_reg;
    logic signed [63:0] j64;
    logic signed [35:0] b5_j_reg;
    logic signed [53:0] b6_jx_reg, b6_jy_reg;
    logic signed [63:0] ix64, iy64, ovx64, ovy64;
    logic               bounce;

    logic               hit_reg;
    logic signed [31:0] out_x_reg, out_y_reg, out_vel_x_reg, out_vel_y_reg;

    // Apply signs to the normal; a centre inside the box points up
    always_comb
    begin
        if (in_tag.zero)
        begin
            nx_next = '0;
            ny_next = $signed({1'b0, Q_ONE});
        end
        else
        begin
            nx_next = in_tag.sx ? -$signed({1'b0, in_qx}) : $signed({1'b0, in_qx});
            ny_next = in_tag.sy ? -$signed({1'b0, in_qy}) : $signed({1'b0, in_qy});
        end
    end

    // Round the products back to Q16.16, clamp the restitution, form the new velocity
    always_comb
    begin
        offx64 = rnd16(64'(b2_pnx_reg));
        offy64 = rnd16(64'(b2_pny_reg));
        dot64  = rnd16(64'(b2_pvx_reg) + 64'(b2_pvy_reg));
        e_lim  = (restitution > Q_ONE) ? Q_ONE : restitution;
        fac    = $signed({2'b00, e_lim}) + $signed({2'b00, Q_ONE});
        j64    = rnd16(64'(b4_jp_reg));
        ix64   = rnd16(64'(b6_jx_reg));
        iy64   = rnd16(64'(b6_jy_reg));
        ovx64  = 64'(b6_tag_reg.vx) - ix64;
        ovy64  = 64'(b6_tag_reg.vy) - iy64;
        bounce = b6_tag_reg.hit && b6_dot_reg[34];
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            b4_valid_reg  <= 1'b0;
            b5_valid_reg  <= 1'b0;
            b6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg  <= in_valid;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            b4_valid_reg  <= b3_valid_reg;
            b5_valid_reg  <= b4_valid_reg;
            b6_valid_reg  <= b5_valid_reg;
            out_valid_reg <= b6_valid_reg;
        end
    end

    // Advance the data stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_tag_reg <= in_tag;
            b1_nx_reg  <= nx_next;
            b1_ny_reg  <= ny_next;

            b2_tag_reg <= b1_tag_reg;
            b2_nx_reg  <= b1_nx_reg;
            b2_ny_reg  <= b1_ny_reg;
            b2_pnx_reg <= b1_nx_reg * $signed({1'b0, b1_tag_reg.r});
            b2_pny_reg <= b1_ny_reg * $signed({1'b0, b1_tag_reg.r});
            b2_pvx_reg <= b1_tag_reg.vx * b1_nx_reg;
            b2_pvy_reg <= b1_tag_reg.vy * b1_ny_reg;

            b3_tag_reg <= b2_tag_reg;
            b3_nx_reg  <= b2_nx_reg;
            b3_ny_reg  <= b2_ny_reg;
            b3_ox_reg  <= 36'(b2_tag_reg.px) + 36'(offx64);
            b3_oy_reg  <= 36'(b2_tag_reg.py) + 36'(offy64);
            b3_dot_reg <= dot64[34:0];

            b4_tag_reg <= b3_tag_reg;
            b4_nx_reg  <= b3_nx_reg;
            b4_ny_reg  <= b3_ny_reg;
            b4_ox_reg  <= b3_ox_reg;
            b4_oy_reg  <= b3_oy_reg;
            b4_dot_reg <= b3_dot_reg;
            b4_jp_reg  <= b3_dot_reg * fac;

            b5_tag_reg <= b4_tag_reg;
            b5_nx_reg  <= b4_nx_reg;
            b5_ny_reg  <= b4_ny_reg;
            b5_ox_reg  <= b4_ox_reg;
            b5_oy_reg  <= b4_oy_reg;
            b5_dot_reg <= b4_dot_reg;
            b5_j_reg   <= j64[35:0];

            b6_tag_reg <= b5_tag_reg;
            b6_ox_reg  <= b5_ox_reg;
            b6_oy_reg  <= b5_oy_reg;
            b6_dot_reg <= b5_dot_reg;
            b6_jx_reg  <= b5_j_reg * b5_nx_reg;
            b6_jy_reg  <= b5_j_reg * b5_ny_reg;

            hit_reg       <= b6_tag_reg.hit;
            out_x_reg     <= b6_tag_reg.hit ? sat32(64'(b6_ox_reg)) : b6_tag_reg.x;
            out_y_reg     <= b6_tag_reg.hit ? sat32(64'(b6_oy_reg)) : b6_tag_reg.y;
            out_vel_x_reg <= bounce ? sat32(ovx64) : b6_tag_reg.vx;
            out_vel_y_reg <= bounce ? sat32(ovy64) : b6_tag_reg.vy;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_vel_x = out_vel_x_reg;
    assign out_vel_y = out_vel_y_reg;

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the circle/box collision and bounce pipeline
`timescale 1ns / 1ps
module tb
    import cbb_pkg::*;
();

    logic         clk;
    logic         rst_n;
    // circle_x, circle_y, vel_x, vel_y, circle_radius, zero pad (lowest bit up)
    logic [159:0] s_tdata;
    logic         s_tvalid;
    logic         s_tready;
    // hit, out_x, out_y, out_vel_x, out_vel_y, zero pad (lowest bit up)
    logic [135:0] m_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // Fields from the highest bit down, so hit lands in bit 0
    typedef struct packed {
        logic [31:0] ovy;
        logic [31:0] ovx;
        logic [31:0] oy;
        logic [31:0] ox;
        logic        hit;
    } bounce_t;

    // Testbench copy of the box registers
    longint  box_cx, box_cy, box_w, box_h, bounce_e;
    bounce_t bounce_q[$];
    int      fail_count;
    int      hold_cycles;
    int      rx_wait;
    int      rx_draw;
    longint  cycle_count;

    circle_box_bounce dut (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = 1'b1;
            #10 clk = 1'b0;
        end
    end

    function automatic longint sext32(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_q16(longint v);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + 32768) >>> 16;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // Resolve one circle against the box
    function automatic bounce_t resolve_circle(logic [159:0] w);
        longint  x, y, vx, vy, r, hw, hh, px, py, dx, dy, adx, ady;
        longint  nx, ny, dot, e, j, root;
        longint  ox, oy, ovx, ovy;
        longint unsigned d2, r2;
        bounce_t res;
        x = sext32(w[31:0]);
        y = sext32(w[63:32]);
        vx = sext32(w[95:64]);
        vy = sext32(w[127:96]);
        r = longint'(w[158:128]);
        hw = box_w >>> 1;
        hh = box_h >>> 1;
        px = x < box_cx - hw ? box_cx - hw : (x > box_cx + hw ? box_cx + hw : x);
        py = y < box_cy - hh ? box_cy - hh : (y > box_cy + hh ? box_cy + hh : y);
        dx = x - px;
        dy = y - py;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        ox = x; oy = y; ovx = vx; ovy = vy;
        res.hit = 1'b0;
        if (adx < r && ady < r)
        begin
            d2 = longint'(adx * adx) + longint'(ady * ady);
            r2 = r * r;
            if (d2 < r2)
            begin
                res.hit = 1'b1;
                if (d2 == 0)
                begin
                    nx = 0;
                    ny = 65536;
                end
                else
                begin
                    root = floor_sqrt(d2);
                    nx = (dx * 65536) / root;
                    ny = (dy * 65536) / root;
                end
                ox = px + round_q16(nx * r);
                oy = py + round_q16(ny * r);
                dot = round_q16(vx * nx + vy * ny);
                if (dot < 0)
                begin
                    e = bounce_e > 65536 ? 65536 : bounce_e;
                    j = round_q16(dot * (65536 + e));
                    ovx = vx - round_q16(j * nx);
                    ovy = vy - round_q16(j * ny);
                end
            end
        end
        res.ox = 32'(clip32(ox));
        res.oy = 32'(clip32(oy));
        res.ovx = 32'(clip32(ovx));
        res.ovy = 32'(clip32(ovy));
        return res;
    endfunction

    // Write one register: setup cycle, then access cycle
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BOX_CENTER_X: box_cx = sext32(value);
            REG_BOX_CENTER_Y: box_cy = sext32(value);
            REG_BOX_WIDTH:    box_w = longint'(value[30:0]);
            REG_BOX_HEIGHT:   box_h = longint'(value[30:0]);
            default:          bounce_e = longint'(value[16:0]);
        endcase
    endtask

    task automatic set_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] w,
                           logic [31:0] h, logic [31:0] e);
        write_reg(REG_BOX_CENTER_X, cx);
        write_reg(REG_BOX_CENTER_Y, cy);
        write_reg(REG_BOX_WIDTH, w);
        write_reg(REG_BOX_HEIGHT, h);
        write_reg(REG_RESTITUTION, e);
    endtask

    // Send one word after a random gap; predict its result on acceptance
    task automatic send_circle(logic [31:0] x, logic [31:0] y, logic [31:0] vx,
                               logic [31:0] vy, logic [30:0] r);
        logic [159:0] w;
        int gap;
        w = {1'b0, r, vy, vx, y, x};
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bounce_q.push_back(resolve_circle(w));
    endtask

    // Wait for the pipeline to drain before touching the registers
    task automatic drain();
        s_tvalid <= 1'b0;
        while (bounce_q.size() != 0) @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    // Random circle near the box so that hits are common
    task automatic send_near(int n);
        logic [31:0] x, y;
        logic [30:0] r;
        repeat (n)
        begin
            x = 32'(box_cx + longint'($urandom_range(0, 32'(2 * (box_w + 4000))))
                    - box_w - 4000);
            y = 32'(box_cy + longint'($urandom_range(0, 32'(2 * (box_h + 4000))))
                    - box_h - 4000);
            r = ($urandom_range(0, 9) == 0) ? 31'($urandom())
                                            : 31'($urandom_range(0, 3 * 65536));
            if ($urandom_range(0, 7) == 0)
            begin
                x = $urandom();
                y = $urandom();
            end
            send_circle(x, y, $urandom(), $urandom(), r);
        end
    endtask

    task automatic test_reset_box();
        // zero-size box, default restitution
        send_circle(32'd0, 32'd0, 32'hffff_0000, 32'hffff_0000, 31'd65536);
        send_circle(32'd100, 32'd0, 32'h0001_0000, 32'd0, 31'd0);
        send_circle(32'h0000_8000, 32'h0000_8000, 32'h8000_0000, 32'h8000_0000,
                    31'h0001_0000);
        drain();
    endtask

    task automatic test_directed();
        set_box(32'd0, 32'd0, 32'h0004_0000, 32'h0002_0001, 32'h0001_ffff);
        // centre inside box, moving down
        send_circle(32'd0, 32'd0, 32'd0, 32'hfff0_0000, 31'h0001_0000);
        // touching exactly: no hit
        send_circle(32'h0003_0000, 32'd0, 32'hffff_0000, 32'd0, 31'h0001_0000);
        // corner hit, moving away and moving in
        send_circle(32'h0002_8000, 32'h0001_8000, 32'h0001_0000, 32'h0001_0000,
                    31'h0001_0000);
        send_circle(32'h0002_8000, 32'h0001_8000, 32'h8000_0000, 32'h8000_0000,
                    31'h0001_0000);
        // far on one axis
        send_circle(32'h0010_0000, 32'd0, 32'd0, 32'd0, 31'h0001_0000);
        // extremes of the fields
        send_circle(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    31'h7fff_ffff);
        send_circle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    31'h7fff_ffff);
        send_circle(32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                    31'h7fff_ffff);
        drain();
        // box at the edges of the range, huge size
        set_box(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                32'd0);
        send_circle(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                    31'h7fff_ffff);
        send_circle(32'd0, 32'd0, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff);
        send_circle(32'h7fff_ffff, 32'h8000_0000, 32'd5, 32'd5, 31'd1);
        drain();
    endtask

    task automatic test_random(int phases, int per_phase);
        repeat (phases)
        begin
            set_box($urandom_range(0, 3) == 0 ? $urandom() : $signed($urandom_range(0, 1 << 22))
                        - (1 << 21),
                    $signed($urandom_range(0, 1 << 22)) - (1 << 21),
                    $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 8 * 65536),
                    $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 8 * 65536),
                    $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 65536));
            send_near(per_phase);
            drain();
        end
    endtask

    // Fill the pipeline while the receiver holds off
    task automatic test_backpressure();
        hold_cycles = 200;
        send_near(150);
        drain();
    endtask

    // Receiver: drops m_tready for a random wait after each word, plus a long hold
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait <= rx_wait - 1;
            m_tready <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            rx_draw = $urandom_range(0, 3);
            rx_wait <= (rx_draw > 0) ? rx_draw - 1 : 0;
            m_tready <= (rx_draw == 0);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted word with the oldest prediction
    always @(posedge clk)
    begin
        bounce_t want;
        bounce_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[128:0];
            if (bounce_q.size() == 0)
            begin
                $error("unexpected word %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = bounce_q.pop_front();
                if (got.hit !== want.hit)
                begin
                    $error("hit exp %0d got %0d", want.hit, got.hit);
                    fail_count++;
                end
                if (got.ox !== want.ox)
                begin
                    $error("out_x exp %h got %h", want.ox, got.ox);
                    fail_count++;
                end
                if (got.oy !== want.oy)
                begin
                    $error("out_y exp %h got %h", want.oy, got.oy);
                    fail_count++;
                end
                if (got.ovx !== want.ovx)
                begin
                    $error("out_vel_x exp %h got %h", want.ovx, got.ovx);
                    fail_count++;
                end
                if (got.ovy !== want.ovy)
                begin
                    $error("out_vel_y exp %h got %h", want.ovy, got.ovy);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        m_tready = 1'b0;
        hold_cycles = 0;
        rx_wait = 0;
        rx_draw = 0;
        fail_count = 0;
        cycle_count = 0;
        box_cx = 0;
        box_cy = 0;
        box_w = 0;
        box_h = 0;
        bounce_e = 49152;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_box();
        test_directed();
        test_backpressure();
        test_random(15, 120);
        if (fail_count == 0 && bounce_q.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
